/* src/tof_pkg.sv */
// Shared constants and the divider cell record for the off-facing tangent unit.
package tof_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Divisor and partial remainder width (largest divisor is a 98-bit square).
  localparam int DW = 98;
  // Dividend width before the fraction shift.
  localparam int NW = 134;
  // Quotient width, one bit per divider cell.
  localparam int QW = 48;

  localparam logic [33:0] K_1E10 = 34'd10000000000;
  localparam logic [16:0] K_1E5  = 17'd100000;

  localparam logic [QW-1:0] POS_LIM = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIM = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic          valid;
    logic          front;
    logic          sat;
    logic [QW-1:0] q;
    logic [QW-1:0] xlo;
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
  } div_cell_t;

endpackage

/* src/tof_div_cell.sv */
// One restoring-division cell: resolves one quotient bit and passes the item on.
module tof_div_cell
  import tof_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  div_cell_t din,
  output div_cell_t dout
);

  logic [DW:0]   r2;
  logic          ge;
  logic [DW:0]   diff;
  div_cell_t     nxt;

  always_comb begin
    r2   = {din.rem, din.xlo[QW-1]};
    ge   = (r2 >= {1'b0, din.den});
    diff = r2 - {1'b0, din.den};
    nxt       = din;
    nxt.rem   = ge ? diff[DW-1:0] : r2[DW-1:0];
    nxt.q     = {din.q[QW-2:0], ge};
    nxt.xlo   = {din.xlo[QW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= nxt.valid;
    end
    if (en) begin
      dout.front <= nxt.front;
      dout.sat   <= nxt.sat;
      dout.q     <= nxt.q;
      dout.xlo   <= nxt.xlo;
      dout.rem   <= nxt.rem;
      dout.den   <= nxt.den;
    end
  end

endmodule

/* src/target_off_facing_tangent_unit.sv */
// Top level of the off-facing tangent unit: front-end arithmetic and the divider chain.
// An input transfer passes through eight front-end stages, one cell per quotient bit in
// a 48-cell divider chain, and the output register.
// Throughput is one item per cycle; the whole pipeline advances together and halts
// only while a finished result sits in the output register under stall.
// Reset (rst, synchronous, active high) clears every stage valid bit and the output
// valid; payload registers are not reset.
module target_off_facing_tangent_unit
  import tof_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [31:0] observer_x,
  input  logic signed [31:0] observer_y,
  input  logic signed [31:0] observer_z,
  input  logic signed [15:0] facing_x,
  input  logic signed [15:0] facing_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] tangent_result
);

  // Location values carry FRAC_BITS + 14 fraction bits after the facing rotation.
  localparam int LOC = FRAC_BITS + 14;
  localparam logic [63:0] ZTHR = ((64'd1 << LOC) - 64'd1) / 64'd100000 + 64'd1;
  localparam int XSH = QW - FRAC_BITS;

  // The pipeline moves as one; it halts only when the output holds a stalled result.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [7:1] v;

  // Stage 1: difference vector, target minus observer.
  logic               func1;
  logic signed [32:0] dx1, dy1, dz1;
  logic signed [15:0] fx1, fz1;

  // Stage 2: the four rotation products and the scaled up component.
  logic               func2;
  logic signed [48:0] p_fzdx, p_fxdz, p_fxdx, p_fzdz;
  logic signed [48:0] ly2;

  // Stage 3: rotated components as magnitudes, plus front and clamp flags.
  logic               func3, front3, clamp3;
  logic [48:0]        ax3, ay3, az3;

  // Stage 4: partial products of the three squares.
  logic               func4, front4, clamp4;
  logic [48:0]        ax4, az4;
  logic [49:0]        xll, yll, zll;
  logic [48:0]        xlh, ylh, zlh;
  logic [47:0]        xhh, yhh, zhh;

  // Stage 5: sum of squares and the squared forward distance.
  logic               func5, front5, clamp5;
  logic [48:0]        ax5, az5;
  logic [98:0]        s5;
  logic [97:0]        az2_5;

  // Stage 6: constant-scaled partial products for the clamped cases.
  logic               func6, front6, clamp6;
  logic [48:0]        ax6, az6;
  logic [98:0]        s6;
  logic [97:0]        az2_6;
  logic [58:0]        sk[4];
  logic [65:0]        axk6;

  // Stage 7: dividend and divisor.
  logic               front7;
  logic [NW-1:0]      num7;
  logic [DW-1:0]      den7;

  logic signed [49:0] lx_c, lz_c;
  logic [24:0]        xlo_c, ylo_c, zlo_c;
  logic [23:0]        xhi_c, yhi_c, zhi_c;
  logic [97:0]        sqx_c, sqy_c;
  logic [99:0]        s_pad;
  logic [132:0]       sk_sum;
  logic [NW-1:0]      xhi_full;

  div_cell_t          chain[QW+1];

  always_comb begin
    lx_c  = 50'(p_fzdx) - 50'(p_fxdz);
    lz_c  = 50'(p_fxdx) + 50'(p_fzdz);
    xlo_c = ax3[24:0];
    xhi_c = ax3[48:25];
    ylo_c = ay3[24:0];
    yhi_c = ay3[48:25];
    zlo_c = az3[24:0];
    zhi_c = az3[48:25];
    sqx_c = (98'(xhh) << 50) + (98'(xlh) << 26) + 98'(xll);
    sqy_c = (98'(yhh) << 50) + (98'(ylh) << 26) + 98'(yll);
    s_pad = {1'b0, s6};
    sk_sum = 133'(sk[0]) + (133'(sk[1]) << 25) + (133'(sk[2]) << 50) + (133'(sk[3]) << 75);
    xhi_full = num7 >> XSH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:1], in_valid};
    end
    if (en) begin
      // Stage 1
      func1 <= func;
      dx1   <= 33'(target_x) - 33'(observer_x);
      dy1   <= 33'(target_y) - 33'(observer_y);
      dz1   <= 33'(target_z) - 33'(observer_z);
      fx1   <= facing_x;
      fz1   <= facing_z;
      // Stage 2
      func2  <= func1;
      p_fzdx <= fz1 * dx1;
      p_fxdz <= fx1 * dz1;
      p_fxdx <= fx1 * dx1;
      p_fzdz <= fz1 * dz1;
      ly2    <= 49'(dy1) <<< 14;
      // Stage 3: z equal to zero counts as in front.
      func3  <= func2;
      front3 <= !lz_c[49];
      ax3    <= lx_c[49] ? 49'(-lx_c) : lx_c[48:0];
      ay3    <= ly2[48] ? 49'(-ly2) : 49'(ly2);
      az3    <= lz_c[49] ? 49'(-lz_c) : lz_c[48:0];
      clamp3 <= (64'(lz_c[49] ? 49'(-lz_c) : lz_c[48:0]) < ZTHR);
      // Stage 4
      func4  <= func3;
      front4 <= front3;
      clamp4 <= clamp3;
      ax4    <= ax3;
      az4    <= az3;
      xll    <= xlo_c * xlo_c;
      xlh    <= 49'(xlo_c * 49'(xhi_c));
      xhh    <= xhi_c * xhi_c;
      yll    <= ylo_c * ylo_c;
      ylh    <= 49'(ylo_c * 49'(yhi_c));
      yhh    <= yhi_c * yhi_c;
      zll    <= zlo_c * zlo_c;
      zlh    <= 49'(zlo_c * 49'(zhi_c));
      zhh    <= zhi_c * zhi_c;
      // Stage 5
      func5  <= func4;
      front5 <= front4;
      clamp5 <= clamp4;
      ax5    <= ax4;
      az5    <= az4;
      s5     <= 99'(sqx_c) + 99'(sqy_c);
      az2_5  <= (98'(zhh) << 50) + (98'(zlh) << 26) + 98'(zll);
      // Stage 6
      func6  <= func5;
      front6 <= front5;
      clamp6 <= clamp5;
      ax6    <= ax5;
      az6    <= az5;
      s6     <= s5;
      az2_6  <= az2_5;
      for (int k = 0; k < 3; k++) begin
        sk[k] <= 59'(s5[k*25 +: 25]) * 59'(K_1E10);
      end
      // The top chunk is only partly populated by the 99-bit sum.
      sk[3]  <= 59'({1'b0, 25'(s5 >> 75)}) * 59'(K_1E10);
      axk6   <= 66'(ax5) * 66'(K_1E5);
      // Stage 7: pick dividend and divisor for the four cases.
      front7 <= front6;
      if (func6) begin
        if (clamp6) begin
          num7 <= NW'(axk6);
          den7 <= DW'(1) << LOC;
        end else begin
          num7 <= NW'(ax6);
          den7 <= DW'(az6);
        end
      end else begin
        if (clamp6) begin
          num7 <= NW'(sk_sum);
          den7 <= DW'(1) << (2 * LOC);
        end else begin
          num7 <= NW'(s_pad);
          den7 <= az2_6;
        end
      end
    end
  end

  // Stage 8: if the upper dividend already reaches the divisor, the quotient
  // needs more than 48 bits and the result saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0].valid <= v[7];
    end
    if (en) begin
      chain[0].front <= front7;
      chain[0].sat   <= (xhi_full >= NW'(den7));
      chain[0].q     <= '0;
      chain[0].xlo   <= QW'(num7 << FRAC_BITS);
      chain[0].rem   <= xhi_full[DW-1:0];
      chain[0].den   <= den7;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_cell
    tof_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Output register: limit, then apply the sign.
  logic [QW-1:0] lim, mag_c;

  always_comb begin
    lim   = chain[QW].front ? POS_LIM : NEG_LIM;
    mag_c = (chain[QW].sat || (chain[QW].q > lim)) ? lim : chain[QW].q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain[QW].valid;
    end
    if (en) begin
      tangent_result <= chain[QW].front ? signed'(mag_c) : signed'(-mag_c);
    end
  end

endmodule

/* src/tof_checker.sv */
// Port-level checker for the off-facing tangent unit, bound to the top level.
module tof_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] tangent_result
);

  // A result held under stall keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tangent_result))
    else $error("result changed while stalled");

  // The input side only waits while the output holds a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

  // No result appears right after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // An empty output register with the input free is not followed by a result held over from before.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !out_valid |=> !(out_valid && $past(out_valid)))
    else $error("output valid without a source");

endmodule

bind target_off_facing_tangent_unit tof_checker u_tof_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .tangent_result (tangent_result)
);

/* bench/tb_target_off_facing_tangent_unit.sv */
// Self-checking bench for the off-facing tangent unit: directed and random transfers.
`timescale 1ns / 100ps

module tb_target_off_facing_tangent_unit
  import tof_pkg::*;
;

  // Function select codes of the func port.
  localparam logic FN_SQ_TAN = 1'b0;
  localparam logic FN_H_TAN  = 1'b1;

  // Location frame is Q.(16+14); forward distances below this count as within 1e-5.
  localparam longint ZTHR = ((64'd1 << 30) - 1) / 100000 + 1;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic               func;
    logic signed [31:0] observer_x, observer_y, observer_z;
    logic signed [15:0] facing_x, facing_z;
    logic signed [31:0] target_x, target_y, target_z;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic signed [31:0] observer_x = '0, observer_y = '0, observer_z = '0;
  logic signed [15:0] facing_x = '0, facing_z = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] tangent_result;

  logic [47:0] tangent_q[$];   // expected results, oldest first
  int bad_results = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;     // asks the receiver for one long stall

  target_off_facing_tangent_unit DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Predicts one result. The geometry is exact integer math in Q.30; the final
  // division keeps 16 fraction bits, truncates toward zero and then saturates.
  function automatic logic [47:0] off_facing_tangent(query_t q);
    longint dx, dy, dz, fx, fz, lx, ly, lz;
    logic [191:0] ax, ay, az, num, den, quo, lim, sq;
    bit front, clamp, ovf;
    dx = longint'(q.target_x) - longint'(q.observer_x);
    dy = longint'(q.target_y) - longint'(q.observer_y);
    dz = longint'(q.target_z) - longint'(q.observer_z);
    fx = longint'(q.facing_x);
    fz = longint'(q.facing_z);
    lx = fz * dx - fx * dz;
    ly = dy * 16384;
    lz = fx * dx + fz * dz;
    front = (lz >= 0);
    ax = 192'(lx < 0 ? -lx : lx);
    ay = 192'(ly < 0 ? -ly : ly);
    az = 192'(lz < 0 ? -lz : lz);
    clamp = (az < 192'(ZTHR));
    lim = front ? 192'(POS_LIM) : 192'(NEG_LIM);
    ovf = 1'b0;
    if (q.func == FN_H_TAN) begin
      num = clamp ? ax * 192'd100000 : ax;
      den = clamp ? (192'd1 << 30) : az;
    end else begin
      sq = ax * ax + ay * ay;
      if (clamp) begin
        // The scaled square must fit in 128 bits, otherwise it is taken as saturated.
        num = sq * 192'd10000000000;
        ovf = (num >= (192'd1 << 128));
        den = 192'd1 << 60;
      end else begin
        num = sq;
        den = az * az;
      end
    end
    quo = ovf ? lim : (num << 16) / den;
    if (quo > lim) quo = lim;
    return front ? quo[47:0] : -quo[47:0];
  endfunction

  // Drives one query at the current edge and returns at the edge that takes it.
  task automatic send_query(query_t q);
    in_valid   <= 1'b1;
    func       <= q.func;
    observer_x <= q.observer_x;
    observer_y <= q.observer_y;
    observer_z <= q.observer_z;
    facing_x   <= q.facing_x;
    facing_z   <= q.facing_z;
    target_x   <= q.target_x;
    target_y   <= q.target_y;
    target_z   <= q.target_z;
    do @(posedge clk); while (in_stall);
    tangent_q.push_back(off_facing_tangent(q));
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random query. Most targets are placed near the observer so that the quotient
  // stays in range; a few use tiny offsets to land inside the reciprocal clamp.
  function automatic query_t random_query();
    query_t q;
    int mode;
    int unsigned span;
    mode = $urandom_range(0, 9);
    q.func = 1'($urandom_range(0, 1));
    q.observer_x = $urandom;
    q.observer_y = $urandom;
    q.observer_z = $urandom;
    if (mode == 0) q.facing_x = 16'($urandom);
    else q.facing_x = 16'($signed($urandom_range(0, 32768)) - 16384);
    if (mode == 1) q.facing_z = 16'($urandom);
    else q.facing_z = 16'($signed($urandom_range(0, 32768)) - 16384);
    if (mode <= 2) begin
      q.target_x = $urandom;
      q.target_y = $urandom;
      q.target_z = $urandom;
    end else begin
      span = (mode == 3) ? 4 : (mode <= 6 ? 32'h0001_0000 : 32'h0100_0000);
      q.target_x = q.observer_x + $signed($urandom_range(0, 2 * span)) - $signed(span);
      q.target_y = q.observer_y + $signed($urandom_range(0, 2 * span)) - $signed(span);
      q.target_z = q.observer_z + $signed($urandom_range(0, 2 * span)) - $signed(span);
    end
    return q;
  endfunction

  function automatic query_t make_query(logic fn, int ox, int oz, int fxv, int fzv,
                                        int tx, int ty, int tz);
    query_t q;
    q.func = fn;
    q.observer_x = ox; q.observer_y = 0; q.observer_z = oz;
    q.facing_x = 16'(fxv); q.facing_z = 16'(fzv);
    q.target_x = tx; q.target_y = ty; q.target_z = tz;
    return q;
  endfunction

  // Receiver: the stall pattern is redrawn at the start of each phase between no stall, light
  // and heavy stalling. A hold request forces one long stall counted here.
  initial begin
    int density;
    int phase_cnt;
    phase_cnt = 0;
    density = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (phase_cnt == 0) density = $urandom_range(0, 2) * 35;
        phase_cnt = (phase_cnt + 1) % 64;
        out_stall <= ($urandom_range(0, 99) < density);
      end
    end
  end

  // Result checker and the watchdog on transfers.
  always @(posedge clk) begin
    logic [47:0] want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (tangent_q.size() == 0) begin
          $error("tangent_result: unexpected result %0d", tangent_result);
          bad_results <= bad_results + 1;
        end else begin
          want = tangent_q.pop_front();
          if (tangent_result !== want) begin
            $error("tangent_result: expected %0d, got %0d", $signed(want), tangent_result);
            bad_results <= bad_results + 1;
          end
        end
      end
    end
  end

  // Field extremes, both functions, the clamp at zero forward distance, targets
  // behind and saturation in both directions.
  task automatic test_directed();
    logic fn;
    for (int f = 0; f < 2; f++) begin
      fn = (f == 0) ? FN_SQ_TAN : FN_H_TAN;
      send_query(make_query(fn, 0, 0, 0, 16384, 32'h0001_0000, 0, 32'h0001_0000));
      send_query(make_query(fn, 0, 0, 0, 16384, 32'h0001_0000, 0, -32'sh0001_0000));
      send_query(make_query(fn, 0, 0, 0, 16384, 32'h0001_0000, 32'h0002_0000, 0));
      send_query(make_query(fn, 0, 0, 0, 16384, 1, 0, 0));
      send_query(make_query(fn, 0, 0, 0, 16384, 1, 1, -1));
      send_query(make_query(fn, 0, 0, 16384, 0, 32'h7FFF_FFFF, 0, 0));
      send_query(make_query(fn, 32'h7FFF_FFFF, 32'h8000_0000, -16384, 0,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_query(make_query(fn, 32'h8000_0000, 32'h7FFF_FFFF, 16'sh7FFF, 16'sh8000,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
      send_query(make_query(fn, 0, 0, 11585, 11585, 32'h0010_0000, 32'h0001_0000, 32'h0000_8000));
      send_query(make_query(fn, 0, 0, 0, -16384, 32'h7FFF_0000, 0, 5));
      send_query(make_query(fn, -5, 7, 0, 0, 3, -9, 12));
    end
    pause_sender(1);
  endtask

  // Bursts of random length with random gaps.
  task automatic test_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && count > 0; i++, count--) send_query(random_query());
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    pause_sender(1);
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 150; i++) send_query(random_query());
    pause_sender(1);
  endtask

  // The sender waits until every outstanding result has come back, then resumes random traffic.
  task automatic test_drain_pause();
    for (int i = 0; i < 60; i++) send_query(random_query());
    pause_sender(1);
    while (tangent_q.size() != 0) @(posedge clk);
    test_random(200);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(600);
    test_backpressure();
    test_drain_pause();
    test_random(400);
    while (tangent_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0 && tangent_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (tangent_q.size() != 0) $error("tangent_result: %0d results missing", tangent_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/tof_pkg.sv
src/tof_div_cell.sv
src/target_off_facing_tangent_unit.sv
src/tof_checker.sv
bench/tb_target_off_facing_tangent_unit.sv
